>>> rtl/core/mqmr_pkg.sv
// shared constants, command type and helpers for the multi-queue match release block
`timescale 1ns / 1ps
`default_nettype none
package mqmr_pkg;

  // fixed field widths
  localparam int ID_W       = 16;
  localparam int PORT_W     = 2;
  localparam int MS_W       = 4;
  localparam int QC_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // release size limit and its counter width
  localparam int MATCH_CAP  = 8;
  localparam int MI_W       = $clog2(MATCH_CAP);

  // defaults for the top level parameters
  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT = 2'd1;

  // register reset values
  localparam logic [MS_W-1:0] MS_RESET = 4'd1;
  localparam logic [QC_W-1:0] QC_RESET = 3'd2;

  // one command from front to back: a drop report or a release walk
  typedef struct packed {
    logic              drop;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
  } cmd_t;

  // clamp the match size into 1 .. MATCH_CAP
  function automatic logic [MS_W-1:0] ms_clamp(input logic [MS_W-1:0] raw);
    logic [MS_W-1:0] res;
    if (raw == '0) begin
      res = MS_W'(1);
    end else if (int'(raw) > MATCH_CAP) begin
      res = MS_W'(MATCH_CAP);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mqmr_ifs.sv
// handshake interfaces for arrivals, results and register writes
`timescale 1ns / 1ps
`default_nettype none

// arrival channel
interface mqmr_arrival_if;
  import mqmr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   entity_id;
  logic [PORT_W-1:0] input_port;
  modport source (output valid, entity_id, input_port, input ready);
  modport sink   (input valid, entity_id, input_port, output ready);
endinterface

// result channel
interface mqmr_result_if;
  import mqmr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   released_id;
  logic [PORT_W-1:0] source_queue;
  logic              last_of_release;
  logic              dropped;
  modport source (output valid, released_id, source_queue, last_of_release, dropped,
                  input ready);
  modport sink   (input valid, released_id, source_queue, last_of_release, dropped,
                  output ready);
endinterface

// register write channel
interface mqmr_cfg_if;
  import mqmr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mqmr_front.sv
// front end: takes arrivals, keeps per-queue counts, writes the store, issues commands
`timescale 1ns / 1ps
`default_nettype none
module mqmr_front #(
  parameter int NUM_QUEUES  = mqmr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqmr_pkg::QUEUE_DEPTH_DEF,
  localparam int QIW = $clog2(NUM_QUEUES),
  localparam int QCW = $clog2(NUM_QUEUES + 1),
  localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mqmr_arrival_if.sink               arrival,
  input  wire logic [mqmr_pkg::MS_W-1:0] ms_eff,
  input  wire logic [QCW-1:0]        qc_eff,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output mqmr_pkg::cmd_t             cmd,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [mqmr_pkg::ID_W-1:0]  wr_data,
  input  wire logic                  pop_valid,
  input  wire logic [QIW-1:0]        pop_queue
);
  import mqmr_pkg::*;

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > MS_W) ? CW : MS_W;

  // tail slot, logical count (after releases are decided) and slots physically in use
  logic [PW-1:0] tail [NUM_QUEUES];
  logic [CW-1:0] cnt  [NUM_QUEUES];
  logic [CW-1:0] occ  [NUM_QUEUES];

  logic [CW-1:0]  cnt_app [NUM_QUEUES];
  logic           active  [NUM_QUEUES];
  logic [QIW-1:0] port_idx;
  logic           port_ok;
  logic           full_log;
  logic           space;
  logic           drop;
  logic           accept;
  logic           append;
  logic           all_met;
  logic           match;

  // classify the arrival
  always_comb begin
    port_idx  = QIW'(arrival.input_port);
    port_ok   = QCW'(arrival.input_port) < qc_eff;
    full_log  = cnt[port_idx] == CW'(QUEUE_DEPTH);
    space     = occ[port_idx] != CW'(QUEUE_DEPTH);
    drop      = !port_ok || full_log;
    arrival.ready = cmd_ready && (drop || space);
    accept    = arrival.valid && arrival.ready;
    append    = accept && !drop;
  end

  // match check over the active queues after the append
  always_comb begin
    all_met = 1'b1;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      cnt_app[q] = cnt[q] + CW'(append && (port_idx == QIW'(q)));
      active[q]  = QCW'(q) < qc_eff;
      if (active[q] && (CMPW'(cnt_app[q]) < CMPW'(ms_eff))) begin
        all_met = 1'b0;
      end
    end
    match = append && all_met;
  end

  // command and store write
  always_comb begin
    cmd_valid = accept && (drop || match);
    cmd.drop  = drop;
    cmd.id    = arrival.entity_id;
    cmd.port  = arrival.input_port;
    wr_en     = append;
    wr_addr   = AW'(port_idx) * AW'(QUEUE_DEPTH) + AW'(tail[port_idx]);
    wr_data   = arrival.entity_id;
  end

  // per-queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        tail[q] <= '0;
        cnt[q]  <= '0;
        occ[q]  <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (match && active[q]) begin
          cnt[q] <= cnt_app[q] - CW'(ms_eff);
        end else begin
          cnt[q] <= cnt_app[q];
        end
        occ[q] <= occ[q] + CW'(append && (port_idx == QIW'(q)))
                         - CW'(pop_valid && (pop_queue == QIW'(q)));
      end
      if (append) begin
        if (tail[port_idx] == PW'(QUEUE_DEPTH - 1)) begin
          tail[port_idx] <= '0;
        end else begin
          tail[port_idx] <= tail[port_idx] + PW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mqmr_cmd_queue.sv
// short command queue between the front end and the release engine
`timescale 1ns / 1ps
`default_nettype none
module mqmr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mqmr_pkg::cmd_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mqmr_pkg::cmd_t     out_data
);
  import mqmr_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  // handshake
  always_comb begin
    in_ready  = count != CNT_W'(CMD_DEPTH);
    out_valid = count != '0;
    out_data  = slots[rd_ptr];
    push      = in_valid && in_ready;
    pop       = out_valid && out_ready;
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mqmr_back.sv
// release engine: holds the entry store and head pointers, walks releases one result at a time
`timescale 1ns / 1ps
`default_nettype none
module mqmr_back #(
  parameter int NUM_QUEUES  = mqmr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqmr_pkg::QUEUE_DEPTH_DEF,
  localparam int QIW = $clog2(NUM_QUEUES),
  localparam int QCW = $clog2(NUM_QUEUES + 1),
  localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  wire mqmr_pkg::cmd_t            cmd,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [mqmr_pkg::ID_W-1:0] wr_data,
  input  wire logic [mqmr_pkg::MS_W-1:0] ms_eff,
  input  wire logic [QCW-1:0]            qc_eff,
  output logic                           pop_valid,
  output logic [QIW-1:0]                 pop_queue,
  mqmr_result_if.source                  result
);
  import mqmr_pkg::*;

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ID_W-1:0]   mem [DEPTH];
  logic [ID_W-1:0]   rd_data;
  logic [PW-1:0]     head [NUM_QUEUES];
  logic [QIW-1:0]    q;
  logic [MI_W-1:0]   i;
  logic              is_drop;
  logic              last_flag;
  logic [ID_W-1:0]   drop_id;
  logic [PORT_W-1:0] res_q;
  logic [AW-1:0]     rd_addr;
  logic              i_last;
  logic              q_last;
  logic              take;

  // walk position
  always_comb begin
    take      = cmd_valid && cmd_ready;
    i_last    = MS_W'(i) == ms_eff - MS_W'(1);
    q_last    = QCW'(q) == qc_eff - QCW'(1);
    rd_addr   = AW'(q) * AW'(QUEUE_DEPTH) + AW'(head[q]);
    pop_valid = state == ST_FETCH;
    pop_queue = q;
    cmd_ready = state == ST_IDLE;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.drop ? ST_EMIT : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (result.ready) begin
          state_next = last_flag ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result beat from registers
  always_comb begin
    result.valid           = state == ST_EMIT;
    result.released_id     = is_drop ? drop_id : rd_data;
    result.source_queue    = res_q;
    result.last_of_release = last_flag;
    result.dropped         = is_drop;
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == ST_FETCH) begin
      rd_data <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      drop_id <= cmd.id;
      res_q   <= cmd.port;
    end else if (state == ST_FETCH) begin
      res_q   <= PORT_W'(q);
    end
  end

  // control state and head pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      q         <= '0;
      i         <= '0;
      is_drop   <= 1'b0;
      last_flag <= 1'b0;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        head[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (take) begin
        is_drop   <= cmd.drop;
        last_flag <= cmd.drop;
        q         <= '0;
        i         <= '0;
      end else if (state == ST_FETCH) begin
        last_flag <= i_last && q_last;
        if (head[q] == PW'(QUEUE_DEPTH - 1)) begin
          head[q] <= '0;
        end else begin
          head[q] <= head[q] + PW'(1);
        end
        if (i_last) begin
          i <= '0;
          q <= q + QIW'(1);
        end else begin
          i <= i + MI_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/multi_queue_match_release_core.sv
// top level of the multi-queue match release block
//
// Arrivals come in on the arrival channel (entity_id, input_port) and are appended
// to the queue of their port. When every active queue holds match_size entries, the
// block releases match_size entries from each active queue, queue 0 first, one beat
// per entity on the result channel; the final beat of a release has last_of_release
// set. An arrival on an inactive port or on a full queue gives one dropped beat.
// Registers are written on the cfg channel (index 0 match_size, 1 queue_count). The
// user must write them only while no arrival is in flight; the block itself does not
// enforce this. cfg.ready is always high. Throughput: the front end takes one
// arrival per cycle while its command queue has room and an appended arrival's
// queue has a free slot. Each command passes through the command queue; the release
// engine takes it in its idle state, then for each result beat reads the store
// (fetch) and offers it from the output register (emit); a drop skips the fetch.
// When the receiver stalls, the current beat holds; arrivals that cause no result
// keep being taken until the command queue fills or a queue's slots are still
// held by entries waiting to be read out.
// Reset empties all queues, sets match_size to 1 and queue_count to 2; the entry
// store needs no clearing since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module multi_queue_match_release_core #(
  parameter int NUM_QUEUES  = mqmr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqmr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mqmr_arrival_if.sink  arrival,
  mqmr_result_if.source result,
  mqmr_cfg_if.sink      cfg
);
  import mqmr_pkg::*;

  localparam int QIW = $clog2(NUM_QUEUES);
  localparam int QCW = $clog2(NUM_QUEUES + 1);
  localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  logic [MS_W-1:0] match_size;
  logic [QC_W-1:0] queue_count;
  logic [MS_W-1:0] ms_eff;
  logic [QCW-1:0]  qc_eff;

  logic            cmd_in_valid;
  logic            cmd_in_ready;
  cmd_t            cmd_in;
  logic            cmd_out_valid;
  logic            cmd_out_ready;
  cmd_t            cmd_out;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [ID_W-1:0] wr_data;
  logic            pop_valid;
  logic [QIW-1:0]  pop_queue;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_size  <= MS_RESET;
      queue_count <= QC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MATCH_SIZE:  match_size  <= cfg.data[MS_W-1:0];
        REG_QUEUE_COUNT: queue_count <= cfg.data[QC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective register values
  always_comb begin
    ms_eff = ms_clamp(match_size);
    if (queue_count == '0) begin
      qc_eff = QCW'(1);
    end else if (int'(queue_count) > NUM_QUEUES) begin
      qc_eff = QCW'(NUM_QUEUES);
    end else begin
      qc_eff = QCW'(queue_count);
    end
  end

  mqmr_front #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .arrival   (arrival),
    .ms_eff    (ms_eff),
    .qc_eff    (qc_eff),
    .cmd_valid (cmd_in_valid),
    .cmd_ready (cmd_in_ready),
    .cmd       (cmd_in),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pop_valid (pop_valid),
    .pop_queue (pop_queue)
  );

  mqmr_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in_valid),
    .in_ready  (cmd_in_ready),
    .in_data   (cmd_in),
    .out_valid (cmd_out_valid),
    .out_ready (cmd_out_ready),
    .out_data  (cmd_out)
  );

  mqmr_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .ms_eff    (ms_eff),
    .qc_eff    (qc_eff),
    .pop_valid (pop_valid),
    .pop_queue (pop_queue),
    .result    (result)
  );

endmodule
`default_nettype wire

>>> rtl/core/mqmr_checker.sv
// port-level checks for the multi-queue match release block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mqmr_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [mqmr_pkg::ID_W-1:0]   res_id,
  input wire logic [mqmr_pkg::PORT_W-1:0] res_queue,
  input wire logic                        res_last,
  input wire logic                        res_drop
);
  import mqmr_pkg::*;

  // nothing is pending right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a dropped beat is always the only beat of its arrival
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_drop |-> res_last)
    else $error("dropped beat without last flag");

  // within a release, each following beat needs a store read (fetch state) first
  a_release_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> !res_valid)
    else $error("release beat without store read gap");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_id) && $stable(res_queue)
      && $stable(res_last) && $stable(res_drop))
    else $error("stalled result beat changed");

endmodule

bind multi_queue_match_release_core mqmr_checker u_mqmr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_id    (result.released_id),
  .res_queue (result.source_queue),
  .res_last  (result.last_of_release),
  .res_drop  (result.dropped)
);
`default_nettype wire
